>>> src/sorted_table_search_defines.svh
// assertion macros for the sorted table search block
// used by the top level only, no other dependencies
`ifndef SORTED_TABLE_SEARCH_DEFINES_SVH
`define SORTED_TABLE_SEARCH_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define STS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sts_pkg.sv
// shared types and constants for the sorted table search block
// no dependencies; imported by controller, datapath and top level
package sts_pkg;

    localparam int VALUE_W             = 32;
    localparam int INDEX_W             = 10;
    localparam int LEN_W               = 11;
    localparam int POS_W               = 10;
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SEARCH = 1'b1
    } t_command;

    typedef struct packed {
        t_command                    command;
        logic [INDEX_W-1:0]          entry_index;
        logic signed [VALUE_W-1:0]   data_value;
    } t_in_item;

    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    position;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE0,
        S_EVAL0,
        S_EVAL,
        S_CHECK
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_we;
        logic cfg_we;
        logic start;
        logic rd_first;
        logic eval;
        logic first;
        logic check;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic len_zero;
        logic last_step;
    } t_dp_sts;

endpackage

>>> src/sts_ctrl.sv
// sequencer for loads, length writes and the halving search
// depends on sts_pkg
module sts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sts_pkg::t_command i_in_cmd,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sts_pkg::t_dp_sts  i_sts,
    output sts_pkg::t_dp_cmd  o_cmd
);
    import sts_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_fire;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign in_fire     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.cfg_we = i_cfg_valid;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in_cmd)
                        CMD_LOAD: begin
                            o_cmd.load_we = 1'b1;
                        end
                        CMD_SEARCH: begin
                            o_cmd.start = 1'b1;
                            n_state     = i_sts.len_zero ? S_CHECK : S_PROBE0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PROBE0: begin
                o_cmd.rd_first = 1'b1;
                n_state        = S_EVAL0;
            end
            S_EVAL0: begin
                o_cmd.eval  = 1'b1;
                o_cmd.first = 1'b1;
                n_state     = i_sts.last_step ? S_CHECK : S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.last_step ? S_CHECK : S_EVAL;
            end
            S_CHECK: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.check = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.check) begin
            n_out_valid = 1'b1;
        end
    end

endmodule

>>> src/sts_dp.sv
// table memory, length register, probe arithmetic and result register
// depends on sts_pkg
module sts_dp #(
    parameter int TABLE_DEPTH = sts_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sts_pkg::t_dp_cmd        i_cmd,
    output sts_pkg::t_dp_sts        o_sts,
    input  sts_pkg::t_in_item       i_in_data,
    input  logic [sts_pkg::LEN_W-1:0] i_cfg_data,
    output sts_pkg::t_out_item      o_out_data
);
    import sts_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = LW + 1;

    logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];

    logic [LW-1:0]             r_len;
    logic [LW-1:0]             r_top;
    logic [LW-1:0]             n_len;
    logic [LW-1:0]             n_top;
    logic signed [VALUE_W-1:0] r_key;
    logic signed [VALUE_W-1:0] r_rdata;
    logic [LW-1:0]             r_base;
    logic [LW-1:0]             r_stride;
    logic                      r_probe_ok;
    t_out_item                 r_res;

    logic          lt;
    logic [LW-1:0] n_base;
    logic [LW-1:0] n_stride;
    logic [PW-1:0] probe;
    logic          n_ok;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          wr_ok;
    logic          found;

    // clamp the written length to the depth, then pick its top power of two
    always_comb begin
        if (32'(i_cfg_data) > 32'(TABLE_DEPTH)) begin
            n_len = LW'(TABLE_DEPTH);
        end else begin
            n_len = LW'(i_cfg_data);
        end
        n_top = '0;
        for (int i = 0; i < LW; i++) begin
            if (n_len[i]) begin
                n_top = LW'(1) << i;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_top <= '0;
        end else if (i_cmd.cfg_we) begin
            r_len <= n_len;
            r_top <= n_top;
        end
    end

    // one halving step: judge the last probe, then form the next address
    always_comb begin
        lt = r_probe_ok && (r_rdata < r_key);
        if (!lt) begin
            n_base = r_base;
        end else if (i_cmd.first) begin
            n_base = r_len - r_top + LW'(1);
        end else begin
            n_base = r_base + r_stride;
        end
        n_stride = r_stride >> 1;
        probe    = PW'(n_base) + PW'(n_stride) - PW'(1);
        if (n_stride == '0) begin
            n_ok = (n_base < r_len);
        end else begin
            n_ok = (probe < PW'(r_len));
        end
        if (i_cmd.rd_first) begin
            rd_addr = AW'(r_top - LW'(1));
        end else if (n_stride == '0) begin
            rd_addr = AW'(n_base);
        end else begin
            rd_addr = AW'(probe);
        end
    end

    assign rd_en = i_cmd.rd_first || i_cmd.eval;
    assign wr_ok = i_cmd.load_we && (32'(i_in_data.entry_index) < 32'(TABLE_DEPTH));
    assign found = r_probe_ok && (r_rdata == r_key);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[AW'(i_in_data.entry_index)] <= i_in_data.data_value;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key      <= i_in_data.data_value;
            r_base     <= '0;
            r_stride   <= r_top;
            r_probe_ok <= 1'b0;
        end
        if (i_cmd.rd_first) begin
            r_probe_ok <= 1'b1;
        end
        if (i_cmd.eval) begin
            r_base     <= n_base;
            r_stride   <= n_stride;
            r_probe_ok <= n_ok;
        end
        if (i_cmd.check) begin
            r_res.found    <= found;
            r_res.position <= found ? POS_W'(r_base) : '0;
        end
    end

    assign o_sts.len_zero  = (r_len == '0);
    assign o_sts.last_step = (r_stride == LW'(1));
    assign o_out_data      = r_res;

endmodule

>>> src/sorted_table_search.sv
// top level of the sorted table search block: lower-bound binary search
// depends on sts_pkg, sts_ctrl, sts_dp and sorted_table_search_defines.svh
//
//   channel   direction  handshake                   payload
//   in        slave      i_in_valid / o_in_ready     i_in_data   (t_in_item)
//   out       master     o_out_valid / i_out_ready   o_out_data  (t_out_item)
//   cfg       slave      i_cfg_valid / o_cfg_ready   i_cfg_data  (table length)
//
// a load is written as it is taken; a search runs from accept through a
// first probe at P-1, halving steps and a final check to the result register,
// P the largest power of two not above the length (an empty table skips to the
// check); the single memory read port paces it at one probe read per step
// reset clears the control state and the length; table contents stay undefined
// a result waits in the output register while the next transaction is taken;
// the search only stalls in its final step if that register is still full
module sorted_table_search #(
    parameter int TABLE_DEPTH = sts_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  sts_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output sts_pkg::t_out_item          o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [sts_pkg::LEN_W-1:0]   i_cfg_data
);
    import sts_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer: idle, first probe at P-1, halving steps, final check
    sts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_cmd    (i_in_data.command),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // datapath: table memory, window base and stride, compare, result
    sts_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .i_in_data  (i_in_data),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );

`include "sorted_table_search_defines.svh"

    // an accepted search always leaves the block busy and not ready for new input
    `STS_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n,
        i_in_valid && o_in_ready && (i_in_data.command == CMD_SEARCH),
        !o_in_ready, "search accepted but block ready next cycle")

    // a load finishes in the cycle it is taken
    `STS_ASSERT_NEXT(a_load_one_cycle, i_clk, i_rst_n,
        i_in_valid && o_in_ready && (i_in_data.command == CMD_LOAD),
        o_in_ready, "load did not return to idle")

    // a new result never overwrites one that is still waiting
    `STS_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n,
        dp_cmd.check, !o_out_valid || i_out_ready, "result register overwritten")

    // a miss always reports position zero
    `STS_ASSERT_NOW(a_miss_pos_zero, i_clk, i_rst_n,
        o_out_valid && !o_out_data.found, o_out_data.position == '0,
        "nonzero position on a miss")

endmodule
